// ===== rtl/core/integer_upscale_ordered_dither_unit_macros.svh =====
// Assertion macros used by the checker file of the upscale dither unit.
`ifndef INTEGER_UPSCALE_ORDERED_DITHER_UNIT_MACROS_SVH
`define INTEGER_UPSCALE_ORDERED_DITHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define IUOD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iuod assertion failed");

// Next-cycle implication, disabled while rst is high.
`define IUOD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iuod assertion failed");

`endif

// ===== rtl/core/iuod_pkg.sv =====
// Package of the upscale dither unit: sizes, register map, types and pixel mapping.
package iuod_pkg;

   // Source frame and scaling limits
   localparam int SRC_WIDTH   = 160;
   localparam int SRC_HEIGHT  = 144;
   localparam int MAX_SCALE   = 12;
   localparam int ADDR_BITS   = 24;

   localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
   localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
   localparam int ROW_W       = $clog2(SRC_HEIGHT);
   localparam int COL_W       = $clog2(SRC_WIDTH);
   localparam int SCL_W       = $clog2(MAX_SCALE + 1);

   // Field widths
   localparam int FIELD_W     = 8;
   localparam int SHADE_W     = 2;
   localparam int PIXEL_W     = 8;
   localparam int ADDR_W      = 24;
   localparam int POS_W       = 12;
   localparam int PITCH_W     = 13;
   localparam int SCALE_REG_W = 4;
   localparam int RECT_Y_W    = 13;
   localparam int RECT_SZ_W   = 11;

   // Canvas coordinate widths, wide enough for dest plus the scaled image
   localparam int CANVAS_X_W  = $clog2((1 << POS_W) + SRC_WIDTH * MAX_SCALE);
   localparam int CANVAS_Y_W  = $clog2((1 << POS_W) + SRC_HEIGHT * MAX_SCALE);

   // Stream packing
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_FIELD_W = PIXEL_W + ADDR_W + POS_W + RECT_Y_W + 2 * RECT_SZ_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;

   // Configuration port
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   typedef enum logic [CSR_AW-3:0] {
      REG_SCALE        = 3'd0,
      REG_DEST_X       = 3'd1,
      REG_DEST_Y       = 3'd2,
      REG_CANVAS_WIDTH = 3'd3,
      REG_QUALITY_MODE = 3'd4,
      REG_FIRST_ROW    = 3'd5,
      REG_LAST_ROW     = 3'd6
   } reg_index_type;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_RENDER = 1'b1
   } action_type;

   typedef struct packed {
      logic [SCALE_REG_W-1:0] scale;
      logic [POS_W-1:0]       dest_x;
      logic [POS_W-1:0]       dest_y;
      logic [PITCH_W-1:0]     canvas_width;
      logic                   quality_mode;
      logic [FIELD_W-1:0]     first_row;
      logic [FIELD_W-1:0]     last_row;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scale:        4'd1,
      dest_x:       12'd0,
      dest_y:       12'd0,
      canvas_width: 13'd1,
      quality_mode: 1'b0,
      first_row:    8'd0,
      last_row:     8'd143
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ADDR,
      ST_EMIT
   } state_type;

   // Shade to gray, shade to dither level, 2x2 threshold matrix
   localparam logic [PIXEL_W-1:0] GRAY_OF [4] = '{8'hFF, 8'hAA, 8'h55, 8'h00};
   localparam logic [2:0]         LEVEL_OF [4] = '{3'd0, 3'd1, 3'd3, 3'd4};
   localparam logic [2:0]         THRESH [2][2] = '{'{3'd0, 3'd2}, '{3'd3, 3'd1}};

   localparam logic [PIXEL_W-1:0] PIX_BLACK = 8'h00;
   localparam logic [PIXEL_W-1:0] PIX_WHITE = 8'hFF;

   // Zero acts as one, anything above the limit acts as the limit
   function automatic logic [SCL_W-1:0] eff_scale(input logic [SCALE_REG_W-1:0] raw);
      logic [SCL_W-1:0] res;
      if (raw == '0) begin
         res = SCL_W'(1);
      end else if (int'(raw) > MAX_SCALE) begin
         res = SCL_W'(MAX_SCALE);
      end else begin
         res = SCL_W'(raw);
      end
      return res;
   endfunction

   // Clamp the last row to the frame height
   function automatic logic [ROW_W-1:0] clamp_row(input logic [FIELD_W-1:0] raw);
      logic [ROW_W-1:0] res;
      if (int'(raw) > SRC_HEIGHT - 1) begin
         res = ROW_W'(SRC_HEIGHT - 1);
      end else begin
         res = ROW_W'(raw);
      end
      return res;
   endfunction

   // Gray level in quality mode, Bayer black/white otherwise
   function automatic logic [PIXEL_W-1:0] shade_pixel(
      input logic               qmode,
      input logic [SHADE_W-1:0] shade,
      input logic               ypar,
      input logic               xpar
   );
      logic [PIXEL_W-1:0] res;
      if (qmode) begin
         res = GRAY_OF[shade];
      end else if (THRESH[ypar][xpar] < LEVEL_OF[shade]) begin
         res = PIX_BLACK;
      end else begin
         res = PIX_WHITE;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/integer_upscale_ordered_dither_unit.sv =====
// Top level of the integer upscaler with ordered dither.
//
//   channel   dir   handshake               carries
//   req_      in    req_tvalid/req_tready   pixel write or render step
//   rsp_      out   rsp_tvalid/rsp_tready   one output replica with address and rectangle
//   csr_      in    APB setup + access      seven configuration registers
//
// A pixel write is done at accept. A render step reads the frame store at
// accept, forms the canvas position in ST_FETCH, the row-times-pitch multiply
// in ST_ADDR, then emits one replica per cycle from the output register while
// the receiver takes them. An empty row range goes straight to ST_EMIT. Reset
// clears the sequencer, cursor and output valid; the frame store holds no reset
// value. A stalled response holds the sequencer; the next request is taken
// while the last replica of a step still waits in the output register.
module integer_upscale_ordered_dither_unit import iuod_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // write_column[7:0], write_row[15:8], shade[17:16]
   input  logic                   req_tuser,   // action[0]
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // pixel[7:0], address[31:8], rect_x[43:32],
                                               // rect_y[56:44], rect_w[67:57], rect_h[78:68]
   output logic                   rsp_tlast,   // last_of_run
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // has_pixel[0], frame_done[1]
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   cfg_type               cfg;
   logic                  ram_wr_en;
   logic [FRAME_AW-1:0]   ram_wr_addr;
   logic [SHADE_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [FRAME_AW-1:0]   ram_rd_addr;
   logic [SHADE_W-1:0]    ram_rd_data;

   iuod_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Frame of shades, one entry per source pixel
   iuod_ram #(
      .WIDTH (SHADE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   iuod_walker u_walker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_action       (action_type'(req_tuser)),
      .req_write_column (req_tdata[FIELD_W-1:0]),
      .req_write_row    (req_tdata[2*FIELD_W-1:FIELD_W]),
      .req_shade        (req_tdata[2*FIELD_W+SHADE_W-1:2*FIELD_W]),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser)
   );

endmodule

// ===== rtl/core/iuod_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module iuod_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/iuod_csr.sv =====
// Configuration registers of the upscale dither unit behind the APB-style port.
module iuod_csr import iuod_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_fire;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_sel)
            REG_SCALE:        cfg_in.scale        = csr_pwdata[SCALE_REG_W-1:0];
            REG_DEST_X:       cfg_in.dest_x       = csr_pwdata[POS_W-1:0];
            REG_DEST_Y:       cfg_in.dest_y       = csr_pwdata[POS_W-1:0];
            REG_CANVAS_WIDTH: cfg_in.canvas_width = csr_pwdata[PITCH_W-1:0];
            REG_QUALITY_MODE: cfg_in.quality_mode = csr_pwdata[0];
            REG_FIRST_ROW:    cfg_in.first_row    = csr_pwdata[FIELD_W-1:0];
            REG_LAST_ROW:     cfg_in.last_row     = csr_pwdata[FIELD_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_sel)
         REG_SCALE:        csr_prdata = CSR_DW'(cfg_ff.scale);
         REG_DEST_X:       csr_prdata = CSR_DW'(cfg_ff.dest_x);
         REG_DEST_Y:       csr_prdata = CSR_DW'(cfg_ff.dest_y);
         REG_CANVAS_WIDTH: csr_prdata = CSR_DW'(cfg_ff.canvas_width);
         REG_QUALITY_MODE: csr_prdata = CSR_DW'(cfg_ff.quality_mode);
         REG_FIRST_ROW:    csr_prdata = CSR_DW'(cfg_ff.first_row);
         REG_LAST_ROW:     csr_prdata = CSR_DW'(cfg_ff.last_row);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/iuod_walker.sv =====
// Render sequencer: cursor walk, frame store access, address math and replica emission.
module iuod_walker import iuod_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   // request side
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  action_type             req_action,
   input  logic [FIELD_W-1:0]     req_write_column,
   input  logic [FIELD_W-1:0]     req_write_row,
   input  logic [SHADE_W-1:0]     req_shade,
   // frame store
   output logic                   ram_wr_en,
   output logic [FRAME_AW-1:0]    ram_wr_addr,
   output logic [SHADE_W-1:0]     ram_wr_data,
   output logic                   ram_rd_en,
   output logic [FRAME_AW-1:0]    ram_rd_addr,
   input  logic [SHADE_W-1:0]     ram_rd_data,
   // response side
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int RMUL_W = ROW_W + SCL_W;
   localparam int CMUL_W = COL_W + SCL_W;
   localparam int CNT_W  = ROW_W + 1;
   localparam int PROD_W = CANVAS_Y_W + PITCH_W;
   localparam int PAD_W  = RSP_TDATA_W - RSP_FIELD_W;

   // Control registers
   state_type              state_ff, state_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [SCL_W-1:0]       sub_ff, sub_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [SCL_W-1:0]       k_ff, k_in;
   logic                   out_valid_ff, out_valid_in;

   // Payload registers
   logic                   empty_ff, empty_in;
   logic                   region_end_ff, region_end_in;
   logic [RMUL_W-1:0]      row_mul_ff, row_mul_in;
   logic [CMUL_W-1:0]      col_mul_ff, col_mul_in;
   logic [RMUL_W-1:0]      y0_mul_ff, y0_mul_in;
   logic [RECT_SZ_W-1:0]   rect_w_ff, rect_w_in;
   logic [RECT_SZ_W-1:0]   rect_h_ff, rect_h_in;
   logic [RECT_Y_W-1:0]    rect_y_ff, rect_y_in;
   logic [CANVAS_Y_W-1:0]  y_ff, y_in;
   logic [CANVAS_X_W-1:0]  x0_ff, x0_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;
   logic [RSP_TUSER_W-1:0] out_user_ff, out_user_in;

   // Combinational
   logic                   req_fire;
   logic                   render_fire;
   logic                   emit_fire;
   logic [SCL_W-1:0]       s;
   logic [ROW_W-1:0]       y0;
   logic [ROW_W-1:0]       y1;
   logic                   region_empty;
   logic                   stale;
   logic [ROW_W-1:0]       fix_row;
   logic [SCL_W-1:0]       fix_sub;
   logic [COL_W-1:0]       fix_col;
   logic                   beat_last;
   logic [PIXEL_W-1:0]     beat_pixel;
   logic [ADDR_W-1:0]      beat_addr;
   logic [RECT_Y_W-1:0]    beat_rect_y;
   logic [RECT_SZ_W-1:0]   beat_rect_w;
   logic [RECT_SZ_W-1:0]   beat_rect_h;
   logic [PROD_W:0]        addr_sum;

   // Region bounds from configuration
   assign s            = eff_scale(cfg.scale);
   assign y1           = clamp_row(cfg.last_row);
   assign y0           = ROW_W'(cfg.first_row);
   assign region_empty = FIELD_W'(y1) < cfg.first_row;

   // Restart a cursor that lies outside the region
   assign stale = (row_ff < y0) || (row_ff > y1) || (sub_ff >= s) ||
                  (int'(col_ff) >= SRC_WIDTH);
   assign fix_row = stale ? y0 : row_ff;
   assign fix_sub = stale ? '0 : sub_ff;
   assign fix_col = stale ? '0 : col_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (render_fire) begin
               state_in = region_empty ? ST_EMIT : ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_fire && beat_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and strobe outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      req_fire    = req_tvalid && req_tready;
      render_fire = req_fire && (req_action == ACT_RENDER);
      emit_fire   = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_tready);
      ram_rd_en   = render_fire;
      ram_wr_en   = req_fire && (req_action == ACT_WRITE) &&
                    (int'(req_write_column) < SRC_WIDTH) &&
                    (int'(req_write_row) < SRC_HEIGHT);
   end

   // Frame store addressing; a write and the read of a later step never share a cycle
   assign ram_wr_addr = FRAME_AW'(req_write_row) * FRAME_AW'(SRC_WIDTH) +
                        FRAME_AW'(req_write_column);
   assign ram_wr_data = req_shade;
   assign ram_rd_addr = FRAME_AW'(fix_row) * FRAME_AW'(SRC_WIDTH) + FRAME_AW'(fix_col);

   // Step setup at accept: products against the scale and rectangle sizes
   always_comb begin
      empty_in      = empty_ff;
      region_end_in = region_end_ff;
      row_mul_in    = row_mul_ff;
      col_mul_in    = col_mul_ff;
      y0_mul_in     = y0_mul_ff;
      rect_w_in     = rect_w_ff;
      rect_h_in     = rect_h_ff;
      if (render_fire) begin
         empty_in      = region_empty;
         region_end_in = (fix_row == y1) && (fix_sub == s - SCL_W'(1)) &&
                         (fix_col == COL_W'(SRC_WIDTH - 1));
         row_mul_in    = RMUL_W'(fix_row) * RMUL_W'(s);
         col_mul_in    = CMUL_W'(fix_col) * CMUL_W'(s);
         y0_mul_in     = RMUL_W'(y0) * RMUL_W'(s);
         rect_w_in     = RECT_SZ_W'(s) * RECT_SZ_W'(SRC_WIDTH);
         rect_h_in     = RECT_SZ_W'(CNT_W'(y1) - CNT_W'(y0) + CNT_W'(1)) * RECT_SZ_W'(s);
      end
   end

   // Canvas position of the run and top of the rectangle
   always_comb begin
      y_in      = y_ff;
      x0_in     = x0_ff;
      rect_y_in = rect_y_ff;
      if (state_ff == ST_FETCH) begin
         y_in      = CANVAS_Y_W'(cfg.dest_y) + CANVAS_Y_W'(row_mul_ff) + CANVAS_Y_W'(fix_sub);
         x0_in     = CANVAS_X_W'(cfg.dest_x) + CANVAS_X_W'(col_mul_ff);
         rect_y_in = RECT_Y_W'(cfg.dest_y) + RECT_Y_W'(y0_mul_ff);
      end
   end

   // Canvas byte offset of the first replica
   assign addr_sum = (PROD_W + 1)'(PROD_W'(y_ff) * PROD_W'(cfg.canvas_width)) +
                     (PROD_W + 1)'(x0_ff);
   always_comb begin
      base_in = base_ff;
      if (state_ff == ST_ADDR) begin
         base_in = ADDR_W'(addr_sum[ADDR_BITS-1:0]);
      end
   end

   // Build the current replica
   always_comb begin
      beat_last   = empty_ff || (k_ff == s - SCL_W'(1));
      beat_pixel  = empty_ff ? '0 :
                    shade_pixel(cfg.quality_mode, ram_rd_data, y_ff[0], x0_ff[0] ^ k_ff[0]);
      beat_addr   = empty_ff ? '0 : base_ff + ADDR_W'(k_ff);
      beat_rect_y = empty_ff ? RECT_Y_W'(cfg.dest_y) : rect_y_ff;
      beat_rect_w = empty_ff ? '0 : rect_w_ff;
      beat_rect_h = empty_ff ? '0 : rect_h_ff;
   end

   // Output register: load on emit, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_data_in  = {{PAD_W{1'b0}}, beat_rect_h, beat_rect_w, beat_rect_y,
                         cfg.dest_x, beat_addr, beat_pixel};
         out_last_in  = beat_last;
         out_user_in  = {empty_ff || (beat_last && region_end_ff), !empty_ff};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Cursor: take the restarted position, advance after the last replica
   always_comb begin
      row_in = row_ff;
      sub_in = sub_ff;
      col_in = col_ff;
      k_in   = k_ff;
      if (render_fire) begin
         k_in = '0;
         if (!region_empty) begin
            row_in = fix_row;
            sub_in = fix_sub;
            col_in = fix_col;
         end
      end else if (emit_fire) begin
         k_in = k_ff + SCL_W'(1);
         if (beat_last && !empty_ff) begin
            if (col_ff == COL_W'(SRC_WIDTH - 1)) begin
               col_in = '0;
               if (sub_ff == s - SCL_W'(1)) begin
                  sub_in = '0;
                  row_in = (row_ff == y1) ? y0 : row_ff + ROW_W'(1);
               end else begin
                  sub_in = sub_ff + SCL_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         sub_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         sub_ff       <= sub_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      empty_ff      <= empty_in;
      region_end_ff <= region_end_in;
      row_mul_ff    <= row_mul_in;
      col_mul_ff    <= col_mul_in;
      y0_mul_ff     <= y0_mul_in;
      rect_w_ff     <= rect_w_in;
      rect_h_ff     <= rect_h_in;
      rect_y_ff     <= rect_y_in;
      y_ff          <= y_in;
      x0_ff         <= x0_in;
      base_ff       <= base_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
      out_user_ff   <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== rtl/core/iuod_checker.sv =====
// Port-level checker of the upscale dither unit and its bind to the top level.
`include "integer_upscale_ordered_dither_unit_macros.svh"

module iuod_checker import iuod_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // Hold a stalled response
   `IUOD_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `IUOD_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // End of region always closes a run
   `IUOD_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast)

   // Empty region reply: single closing replica with zero pixel, address and size
   `IUOD_ASSERT_IMPL(a_empty_shape, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tlast && rsp_tuser[1] && (rsp_tdata[31:0] == '0) && (rsp_tdata[78:57] == '0))

   // Replicas of one run follow without gaps
   `IUOD_ASSERT_NEXT(a_run_continuous, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

endmodule

bind integer_upscale_ordered_dither_unit iuod_checker u_iuod_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the integer upscaler with ordered dither.
`timescale 1ns / 100ps

module testbench;
   import iuod_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 32;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 14;
   localparam int SWEEP_RENDERS = 36;

   // Pixel mapping tables of the frame model
   localparam logic [7:0] GRAY_LEVEL [4]   = '{8'hFF, 8'hAA, 8'h55, 8'h00};
   localparam logic [2:0] DITHER_LEVEL [4] = '{3'd0, 3'd1, 3'd3, 3'd4};
   localparam logic [2:0] BAYER [2][2]     = '{'{3'd0, 3'd2}, '{3'd3, 3'd1}};

   typedef struct packed {
      logic [7:0]  pixel;
      logic [23:0] address;
      logic        has_pixel;
      logic        last_of_run;
      logic        frame_done;
      logic [11:0] rect_x;
      logic [12:0] rect_y;
      logic [10:0] rect_w;
      logic [10:0] rect_h;
   } replica_type;

   typedef enum logic {
      ROW_REGISTER,
      ROW_REQUEST
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type reg_idx;
      int unsigned   value;
      action_type    act;
      logic [7:0]    col;
      logic [7:0]    row;
      logic [1:0]    shade;
      bit            typed;
      replica_type   want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // write_column[7:0], write_row[15:8], shade[17:16]
   logic                   req_tuser = 1'b0; // action[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // pixel[7:0], address[31:8], rect_x[43:32],
                                             // rect_y[56:44], rect_w[67:57], rect_h[78:68]
   logic                   rsp_tlast;        // last_of_run
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // has_pixel[0], frame_done[1]
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // Register copy and cursor of the frame model
   logic [3:0]  set_scale = 4'd1;
   logic [11:0] set_dest_x = '0;
   logic [11:0] set_dest_y = '0;
   logic [12:0] set_pitch = 13'd1;
   logic        set_quality = 1'b0;
   logic [7:0]  set_first = '0;
   logic [7:0]  set_last = 8'd143;
   logic [7:0]  view_row = '0;
   logic [3:0]  view_subrow = '0;
   logic [7:0]  view_col = '0;
   logic [1:0]  frame_shades [FRAME_DEPTH];
   bit          frame_written [FRAME_DEPTH];

   replica_type pending_replicas[$];
   replica_type step_replicas[$];

   bit          req_idle_on = 1'b1;
   logic        rsp_idle_on = 1'b1;
   int          hold_token = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          cycle_count = 0;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          renders_sent = 0;
   int          replicas_checked = 0;
   int          register_writes = 0;
   int          frame_ends = 0;

   integer_upscale_ordered_dither_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic string replica_text(replica_type r);
      return $sformatf("pix=%h addr=%h has=%0b last=%0b done=%0b rect=(%0d,%0d,%0d,%0d)",
                       r.pixel, r.address, r.has_pixel, r.last_of_run, r.frame_done,
                       r.rect_x, r.rect_y, r.rect_w, r.rect_h);
   endfunction

   function automatic replica_type make_replica(logic [7:0] pix, logic [23:0] addr, logic has,
                                                logic last, logic done, logic [11:0] rx,
                                                logic [12:0] ry, logic [10:0] rw,
                                                logic [10:0] rh);
      return '{pix, addr, has, last, done, rx, ry, rw, rh};
   endfunction

   task automatic flag_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // Scale and row range as the block applies them
   function automatic int unsigned scale_used();
      if (set_scale == 4'd0) return 1;
      if (set_scale > MAX_SCALE) return MAX_SCALE;
      return set_scale;
   endfunction

   function automatic int unsigned row_end();
      return (set_last > SRC_HEIGHT - 1) ? SRC_HEIGHT - 1 : set_last;
   endfunction

   function automatic bit cursor_stale();
      return (view_row < set_first) || (view_row > row_end()) ||
             (view_subrow >= scale_used()) || (view_col >= SRC_WIDTH);
   endfunction

   // Frame entry the next render step reads, or -1 for an empty region
   function automatic int next_read_index();
      logic [7:0] r;
      logic [7:0] c;
      if (row_end() < set_first) return -1;
      r = view_row;
      c = view_col;
      if (cursor_stale()) begin
         r = set_first;
         c = '0;
      end
      return int'(r) * SRC_WIDTH + int'(c);
   endfunction

   function automatic void store_pixel(logic [7:0] col, logic [7:0] row, logic [1:0] shade);
      if (col < SRC_WIDTH && row < SRC_HEIGHT) begin
         frame_shades[int'(row) * SRC_WIDTH + int'(col)] = shade;
         frame_written[int'(row) * SRC_WIDTH + int'(col)] = 1'b1;
      end
   endfunction

   // Compute the replicas of one render step and advance the cursor
   function automatic void render_replicas();
      int unsigned s, y0, y1, y, x;
      logic [1:0]  sh;
      bit          at_end;
      replica_type r;
      s = scale_used();
      y0 = set_first;
      y1 = row_end();
      step_replicas.delete();
      if (y1 < y0) begin
         r = '0;
         r.last_of_run = 1'b1;
         r.frame_done = 1'b1;
         r.rect_x = set_dest_x;
         r.rect_y = 13'(set_dest_y);
         step_replicas.push_back(r);
         return;
      end
      if (cursor_stale()) begin
         view_row = 8'(y0);
         view_subrow = '0;
         view_col = '0;
      end
      sh = frame_shades[int'(view_row) * SRC_WIDTH + int'(view_col)];
      y = set_dest_y + view_row * s + view_subrow;
      at_end = (view_row == y1) && (view_subrow == s - 1) && (view_col == SRC_WIDTH - 1);
      for (int k = 0; k < s; k++) begin
         x = set_dest_x + view_col * s + k;
         if (set_quality) r.pixel = GRAY_LEVEL[sh];
         else r.pixel = (BAYER[y % 2][x % 2] < DITHER_LEVEL[sh]) ? 8'h00 : 8'hFF;
         r.address = 24'(y * set_pitch + x);
         r.has_pixel = 1'b1;
         r.last_of_run = (k == s - 1);
         r.frame_done = (k == s - 1) && at_end;
         r.rect_x = set_dest_x;
         r.rect_y = 13'(set_dest_y + y0 * s);
         r.rect_w = 11'(s * SRC_WIDTH);
         r.rect_h = 11'((y1 - y0 + 1) * s);
         step_replicas.push_back(r);
      end
      // Walk columns, then sub-rows, then rows, wrapping to the first row
      view_col++;
      if (view_col >= SRC_WIDTH) begin
         view_col = '0;
         view_subrow++;
         if (view_subrow >= s) begin
            view_subrow = '0;
            view_row++;
            if (view_row > y1) view_row = 8'(y0);
         end
      end
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_item(action_type act, logic [7:0] col, logic [7:0] row,
                            logic [1:0] shade, bit typed, replica_type want);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (act == ACT_WRITE) begin
         store_pixel(col, row, shade);
      end else begin
         render_replicas();
         renders_sent++;
         if (typed) pending_replicas.push_back(want);
         else foreach (step_replicas[i]) pending_replicas.push_back(step_replicas[i]);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= REQ_TDATA_W'({shade, row, col});
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // Write the pixel under the cursor first if it was never written, then render
   task automatic send_render(bit typed, replica_type want);
      int idx;
      idx = next_read_index();
      if (idx >= 0 && !frame_written[idx])
         send_item(ACT_WRITE, 8'(idx % SRC_WIDTH), 8'(idx / SRC_WIDTH),
                   2'($urandom_range(0, 3)), 1'b0, '0);
      send_item(ACT_RENDER, 8'($urandom), 8'($urandom), 2'($urandom), typed, want);
   endtask

   task automatic wait_for_replicas();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_replicas.size() != 0);
   endtask

   task automatic quiesce();
      wait_for_replicas();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB setup and access phases, then the bus returns to idle
   task automatic write_register(reg_index_type idx, int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      register_writes++;
      case (idx)
         REG_SCALE:        set_scale = value[3:0];
         REG_DEST_X:       set_dest_x = value[11:0];
         REG_DEST_Y:       set_dest_y = value[11:0];
         REG_CANVAS_WIDTH: set_pitch = value[12:0];
         REG_QUALITY_MODE: set_quality = value[0];
         REG_FIRST_ROW:    set_first = value[7:0];
         REG_LAST_ROW:     set_last = value[7:0];
         default: ;
      endcase
   endtask

   task automatic program_setup(int unsigned sc, int unsigned dx, int unsigned dy,
                                int unsigned pitch, int unsigned q, int unsigned fr,
                                int unsigned lr);
      quiesce();
      write_register(REG_SCALE, sc);
      write_register(REG_DEST_X, dx);
      write_register(REG_DEST_Y, dy);
      write_register(REG_CANVAS_WIDTH, pitch);
      write_register(REG_QUALITY_MODE, q);
      write_register(REG_FIRST_ROW, fr);
      write_register(REG_LAST_ROW, lr);
   endtask

   // Draw a register setting, either from the extremes or from the whole range
   task automatic program_random_setup(bit extreme);
      int unsigned sc, dx, dy, pitch, fr, lr;
      if (extreme) begin
         case ($urandom_range(0, 3))
            0: sc = 0;
            1: sc = 1;
            2: sc = MAX_SCALE;
            default: sc = 15;
         endcase
         dx = $urandom_range(0, 1) ? 4095 : 0;
         dy = $urandom_range(0, 1) ? 4095 : 0;
         case ($urandom_range(0, 3))
            0: pitch = 0;
            1: pitch = 1;
            2: pitch = 4096;
            default: pitch = 8191;
         endcase
      end else begin
         sc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_SCALE);
         dx = $urandom_range(0, 4095);
         dy = $urandom_range(0, 4095);
         pitch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      end
      if ($urandom_range(0, 9) == 0) begin
         fr = $urandom_range(1, 255);
         lr = $urandom_range(0, fr - 1);
      end else begin
         fr = $urandom_range(0, SRC_HEIGHT - 1);
         lr = $urandom_range(fr, 255);
      end
      program_setup(sc, dx, dy, pitch, $urandom_range(0, 1), fr, lr);
   endtask

   function automatic stim_row_type reg_row(reg_index_type idx, int unsigned value);
      stim_row_type r;
      r = '{ROW_REGISTER, idx, value, ACT_WRITE, '0, '0, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type req_row(action_type act, logic [7:0] col, logic [7:0] row,
                                            logic [1:0] shade);
      stim_row_type r;
      r = '{ROW_REQUEST, REG_SCALE, 0, act, col, row, shade, 1'b0, '0};
      return r;
   endfunction

   function automatic stim_row_type checked_row(replica_type want);
      stim_row_type r;
      r = '{ROW_REQUEST, REG_SCALE, 0, ACT_RENDER, '0, '0, '0, 1'b1, want};
      return r;
   endfunction

   // Receiver: check every accepted response, stall at random or on a long hold
   always @(posedge clock) begin : response_side
      replica_type got;
      replica_type oldest;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[31:8], rsp_tuser[0], rsp_tlast, rsp_tuser[1],
                   rsp_tdata[43:32], rsp_tdata[56:44], rsp_tdata[67:57], rsp_tdata[78:68]};
            if (got.has_pixel && got.frame_done) frame_ends++;
            if (pending_replicas.size() == 0) begin
               flag_failure({"response with nothing expected: ", replica_text(got)});
            end else begin
               oldest = pending_replicas.pop_front();
               replicas_checked++;
               if (got !== oldest)
                  flag_failure({"expected ", replica_text(oldest), " got ", replica_text(got)});
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type directed_rows[$];
      bit           extreme;
      int           pick;
      int           sweep_row;

      // Directed rows: reset values, both modes, extremes and the corner cases
      directed_rows.push_back(req_row(ACT_WRITE, 8'd0, 8'd0, 2'd3));
      directed_rows.push_back(checked_row(make_replica(8'h00, 24'd0, 1'b1, 1'b1, 1'b0,
                                                       12'd0, 13'd0, 11'd160, 11'd144)));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd1, 8'd0, 2'd0));
      directed_rows.push_back(checked_row(make_replica(8'hFF, 24'd1, 1'b1, 1'b1, 1'b0,
                                                       12'd0, 13'd0, 11'd160, 11'd144)));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd2, 8'd0, 2'd1));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd3, 8'd0, 2'd2));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      directed_rows.push_back(reg_row(REG_QUALITY_MODE, 1));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd4, 8'd0, 2'd2));
      directed_rows.push_back(checked_row(make_replica(8'h55, 24'd4, 1'b1, 1'b1, 1'b0,
                                                       12'd0, 13'd0, 11'd160, 11'd144)));
      // Largest scale and offsets, last source row with a clamped end row
      directed_rows.push_back(reg_row(REG_SCALE, MAX_SCALE));
      directed_rows.push_back(reg_row(REG_DEST_X, 4095));
      directed_rows.push_back(reg_row(REG_DEST_Y, 4095));
      directed_rows.push_back(reg_row(REG_CANVAS_WIDTH, 4096));
      directed_rows.push_back(reg_row(REG_FIRST_ROW, 143));
      directed_rows.push_back(reg_row(REG_LAST_ROW, 255));
      directed_rows.push_back(reg_row(REG_QUALITY_MODE, 0));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd0, 8'd143, 2'd1));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd1, 8'd143, 2'd2));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      // Writes outside the frame are dropped; the last pixel of the frame is still written
      directed_rows.push_back(req_row(ACT_WRITE, 8'd160, 8'd0, 2'd3));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd255, 8'd255, 2'd3));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd0, 8'd144, 2'd3));
      directed_rows.push_back(req_row(ACT_WRITE, 8'd159, 8'd143, 2'd2));
      // Scale zero and above the limit, pitch zero and above the canvas range
      directed_rows.push_back(reg_row(REG_SCALE, 0));
      directed_rows.push_back(reg_row(REG_CANVAS_WIDTH, 0));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      directed_rows.push_back(reg_row(REG_SCALE, 15));
      directed_rows.push_back(reg_row(REG_CANVAS_WIDTH, 8191));
      directed_rows.push_back(reg_row(REG_QUALITY_MODE, 1));
      directed_rows.push_back(req_row(ACT_RENDER, 8'd0, 8'd0, 2'd0));
      // Empty row ranges: reversed, and a first row past the frame
      directed_rows.push_back(reg_row(REG_FIRST_ROW, 200));
      directed_rows.push_back(reg_row(REG_LAST_ROW, 100));
      directed_rows.push_back(checked_row(make_replica(8'h00, 24'd0, 1'b0, 1'b1, 1'b1,
                                                       12'd4095, 13'd4095, 11'd0, 11'd0)));
      directed_rows.push_back(reg_row(REG_FIRST_ROW, 144));
      directed_rows.push_back(reg_row(REG_LAST_ROW, 255));
      directed_rows.push_back(checked_row(make_replica(8'h00, 24'd0, 1'b0, 1'b1, 1'b1,
                                                       12'd4095, 13'd4095, 11'd0, 11'd0)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REGISTER) begin
            quiesce();
            write_register(directed_rows[i].reg_idx, directed_rows[i].value);
         end else if (directed_rows[i].act == ACT_RENDER) begin
            send_render(directed_rows[i].typed, directed_rows[i].want);
         end else begin
            send_item(ACT_WRITE, directed_rows[i].col, directed_rows[i].row,
                      directed_rows[i].shade, 1'b0, '0);
         end
      end

      // Random phases: mostly renders over written pixels, some writes and noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         extreme = (p == 0) || (p == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
         program_random_setup(extreme);
         req_idle_on = (p != 0);
         rsp_idle_on <= (p != 0);
         if (p == 1) hold_token <= hold_token + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == PHASE_ITEMS / 2) wait_for_replicas();
            pick = $urandom_range(0, 9);
            if (pick < 6)
               send_render(1'b0, '0);
            else if (pick < 8)
               send_item(ACT_WRITE, 8'($urandom_range(0, SRC_WIDTH - 1)),
                         8'($urandom_range(0, SRC_HEIGHT - 1)), 2'($urandom), 1'b0, '0);
            else
               send_item(ACT_WRITE, 8'($urandom), 8'($urandom), 2'($urandom), 1'b0, '0);
         end
      end

      // Walk along one source row at unit scale under a long receiver hold
      sweep_row = $urandom_range(0, SRC_HEIGHT - 1);
      program_setup($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(1, 4096), $urandom_range(0, 1), sweep_row,
                    (sweep_row == SRC_HEIGHT - 1) ? $urandom_range(sweep_row, 255) : sweep_row);
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      hold_token <= hold_token + 1;
      for (int n = 0; n < SWEEP_RENDERS; n++) send_render(1'b0, '0);

      // Drain and let the pipeline settle
      wait_for_replicas();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_replicas.size() != 0) flag_failure("replicas still outstanding at end of run");
      $display("Run: %0d requests (%0d render steps), %0d replicas, %0d register writes",
               requests_sent, renders_sent, replicas_checked, register_writes);
      $display("Both pixel modes, empty and clamped regions, odd scale and pitch, %0d frame ends",
               frame_ends);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
